### hdl/phd_pkg.sv
package phd_pkg;

    localparam int COUNT_W = 17;
    localparam int CFG_INDEX_W = 8;

    localparam logic [COUNT_W-1:0] HEADER_BYTES = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [COUNT_W-1:0] POS_MAGIC0 = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] POS_MAGIC1 = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_TYPE = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] POS_LEN_LO = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] POS_LEN_HI = COUNT_W'(4);

    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_FIRST = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_SECOND = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_SHORT = 2'd1,
        ERR_MAGIC = 2'd2,
        ERR_SIZE  = 2'd3
    } err_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_last;
    } rx_item_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        err_t        error_code;
        logic [7:0]  message_type;
        logic [15:0] payload_length;
    } res_item_t;

endpackage

### hdl/packet_header_deframer.sv
// a result is registered and presented in the cycle after its byte is transferred
// throughput: one byte per cycle; the result register frees as it is taken,
// so rx_ready only drops while a result is held by res_ready low
// reset: rst_n is asynchronous, active low; it clears the byte counter,
// the captured header, the magic registers and the result valid flag
module packet_header_deframer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rx_valid,
    output logic                              rx_ready,
    input  phd_pkg::rx_item_t                 rx_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output phd_pkg::res_item_t                res_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [phd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [7:0]                        cfg_data
);

    logic [7:0]                   magic_first_reg;
    logic [7:0]                   magic_second_reg;
    logic [phd_pkg::COUNT_W-1:0]  byte_count_reg;
    logic [phd_pkg::COUNT_W-1:0]  byte_count_next;
    logic                         magic_bad_reg;
    logic                         magic_bad_next;
    logic [7:0]                   type_reg;
    logic [7:0]                   type_next;
    logic [15:0]                  length_reg;
    logic [15:0]                  length_next;
    logic                         res_valid_reg;
    phd_pkg::res_item_t           res_data_reg;
    phd_pkg::res_item_t           res_data_next;

    logic                         rx_fire;
    logic [phd_pkg::COUNT_W-1:0]  total;
    logic [phd_pkg::COUNT_W-1:0]  pay_offset;
    logic [phd_pkg::COUNT_W-1:0]  expect_total;
    logic [7:0]                   frame_type;
    logic [15:0]                  frame_length;
    logic                         frame_magic_bad;

    assign cfg_ready = 1'b1;
    assign rx_ready  = !res_valid_reg || res_ready;
    assign rx_fire   = rx_valid && rx_ready;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb
    begin
        frame_magic_bad = magic_bad_reg;
        frame_type      = type_reg;
        frame_length    = length_reg;
        res_data_next   = '0;
        pay_offset      = byte_count_reg - phd_pkg::HEADER_BYTES;

        priority if (byte_count_reg == phd_pkg::POS_MAGIC0)
        begin
            frame_magic_bad = (rx_data.rx_byte != magic_first_reg);
        end
        else if (byte_count_reg == phd_pkg::POS_MAGIC1)
        begin
            frame_magic_bad = magic_bad_reg || (rx_data.rx_byte != magic_second_reg);
        end
        else if (byte_count_reg == phd_pkg::POS_TYPE)
        begin
            frame_type = rx_data.rx_byte;
        end
        else if (byte_count_reg == phd_pkg::POS_LEN_LO)
        begin
            frame_length = {length_reg[15:8], rx_data.rx_byte};
        end
        else if (byte_count_reg == phd_pkg::POS_LEN_HI)
        begin
            frame_length = {rx_data.rx_byte, length_reg[7:0]};
        end
        else
        begin
            // pass while magic is good and declared length not yet reached
            if (!magic_bad_reg && (pay_offset < {1'b0, length_reg}))
            begin
                res_data_next.payload_valid = 1'b1;
                res_data_next.payload_byte  = rx_data.rx_byte;
            end
        end

        // saturating count
        total = (byte_count_reg == phd_pkg::COUNT_MAX) ? byte_count_reg
                                                        : byte_count_reg + 1'b1;
        expect_total = phd_pkg::HEADER_BYTES + {1'b0, frame_length};

        byte_count_next = total;
        magic_bad_next  = frame_magic_bad;
        type_next       = frame_type;
        length_next     = frame_length;

        if (rx_data.buffer_last)
        begin
            res_data_next.frame_done     = 1'b1;
            res_data_next.message_type   = frame_type;
            res_data_next.payload_length = frame_length;
            priority if (total < phd_pkg::HEADER_BYTES)
                res_data_next.error_code = phd_pkg::ERR_SHORT;
            else if (frame_magic_bad)
                res_data_next.error_code = phd_pkg::ERR_MAGIC;
            else if (total != expect_total)
                res_data_next.error_code = phd_pkg::ERR_SIZE;
            else
                res_data_next.error_code = phd_pkg::ERR_OK;
            byte_count_next = '0;
            magic_bad_next  = 1'b0;
            type_next       = '0;
            length_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_first_reg  <= '0;
            magic_second_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == phd_pkg::REG_MAGIC_FIRST)
                magic_first_reg <= cfg_data;
            else if (cfg_index == phd_pkg::REG_MAGIC_SECOND)
                magic_second_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            magic_bad_reg  <= 1'b0;
            type_reg       <= '0;
            length_reg     <= '0;
        end
        else if (rx_fire)
        begin
            byte_count_reg <= byte_count_next;
            magic_bad_reg  <= magic_bad_next;
            type_reg       <= type_next;
            length_reg     <= length_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (rx_fire)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
            res_data_reg <= res_data_next;
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fire && rx_data.buffer_last |=> byte_count_reg == '0 && !magic_bad_reg)
        else $error("frame state not cleared after last byte");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fire && !rx_data.buffer_last && byte_count_reg != phd_pkg::COUNT_MAX
        |=> byte_count_reg == $past(byte_count_reg) + 1'b1)
        else $error("byte counter did not advance");

    a_verdict_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.frame_done
        |-> res_data.error_code == phd_pkg::ERR_OK && res_data.message_type == '0
            && res_data.payload_length == '0)
        else $error("verdict fields set on a non-final result");

    a_no_payload_bad_magic: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.payload_valid
        |-> res_data.error_code != phd_pkg::ERR_MAGIC)
        else $error("payload passed on a frame with bad magic");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.payload_valid |-> res_data.payload_byte == '0)
        else $error("payload byte not zero without payload_valid");

endmodule

### dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               pinned;
        phd_pkg::res_item_t val;
    } pin_t;

    typedef struct packed {
        logic [7:0]         b;
        logic               last;
        logic               pinned;
        phd_pkg::res_item_t want;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            rx_valid;
    logic                            rx_ready;
    phd_pkg::rx_item_t               rx_data;
    logic                            res_valid;
    logic                            res_ready;
    phd_pkg::res_item_t              res_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [phd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]                      cfg_data;

    // deframer state as predicted from the transfers seen so far
    logic [7:0]                  magic0_cfg = 8'h00;
    logic [7:0]                  magic1_cfg = 8'h00;
    logic [phd_pkg::COUNT_W-1:0] rx_count = '0;
    logic                        magic_mismatch = 1'b0;
    logic [7:0]                  type_seen = 8'h00;
    logic [15:0]                 len_seen = 16'h0000;

    phd_pkg::res_item_t deframed_q[$];
    pin_t               pinned_q[$];
    dir_row_t           dir_rows[$];

    bit mismatch_seen = 1'b0;
    int item_count = 0;
    int idle_pct = 0;
    int stall_left = 0;

    packet_header_deframer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_data   (rx_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic phd_pkg::res_item_t deframe_byte(input phd_pkg::rx_item_t it);
        phd_pkg::res_item_t          r;
        logic [phd_pkg::COUNT_W-1:0] pos;
        logic [phd_pkg::COUNT_W-1:0] total;
        r = '0;
        pos = rx_count;
        case (pos)
            phd_pkg::POS_MAGIC0: magic_mismatch = (it.rx_byte != magic0_cfg);
            phd_pkg::POS_MAGIC1:
                if (it.rx_byte != magic1_cfg)
                    magic_mismatch = 1'b1;
            phd_pkg::POS_TYPE:   type_seen = it.rx_byte;
            phd_pkg::POS_LEN_LO: len_seen[7:0] = it.rx_byte;
            phd_pkg::POS_LEN_HI: len_seen[15:8] = it.rx_byte;
            default:
                if (!magic_mismatch && (pos - phd_pkg::HEADER_BYTES) < {1'b0, len_seen})
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte = it.rx_byte;
                end
        endcase
        total = (pos < phd_pkg::COUNT_MAX) ? pos + 1'b1 : phd_pkg::COUNT_MAX;
        rx_count = total;
        if (it.buffer_last)
        begin
            r.frame_done = 1'b1;
            r.message_type = type_seen;
            r.payload_length = len_seen;
            if (total < phd_pkg::HEADER_BYTES)
                r.error_code = phd_pkg::ERR_SHORT;
            else if (magic_mismatch)
                r.error_code = phd_pkg::ERR_MAGIC;
            else if (total != phd_pkg::HEADER_BYTES + len_seen)
                r.error_code = phd_pkg::ERR_SIZE;
            else
                r.error_code = phd_pkg::ERR_OK;
            rx_count = '0;
            magic_mismatch = 1'b0;
            type_seen = 8'h00;
            len_seen = 16'h0000;
        end
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
            mismatch_seen = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        phd_pkg::res_item_t want;
        phd_pkg::res_item_t got;
        pin_t               pin;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (deframed_q.size() == 0)
                begin
                    $display("%0t ns: result transfer with no byte outstanding", $time);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    want = deframed_q.pop_front();
                    check_field("payload_valid", 16'(want.payload_valid),
                                16'(res_data.payload_valid));
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(res_data.payload_byte));
                    check_field("frame_done", 16'(want.frame_done),
                                16'(res_data.frame_done));
                    check_field("error_code", 16'(want.error_code),
                                16'(res_data.error_code));
                    check_field("message_type", 16'(want.message_type),
                                16'(res_data.message_type));
                    check_field("payload_length", want.payload_length,
                                res_data.payload_length);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == phd_pkg::REG_MAGIC_FIRST)
                    magic0_cfg = cfg_data;
                else if (cfg_index == phd_pkg::REG_MAGIC_SECOND)
                    magic1_cfg = cfg_data;
            end
            if (rx_valid && rx_ready)
            begin
                got = deframe_byte(rx_data);
                pin = pinned_q.pop_front();
                deframed_q = {deframed_q, pin.pinned ? pin.val : got};
            end
        end
    end

    // result side back-pressure: random stalls on res_ready, started at a rate set by idle_pct
    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                res_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                res_ready <= 1'b0;
                stall_left = int'($urandom_range(0, 14));
            end
            else
                res_ready <= 1'b1;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_byte(input logic [7:0] b, input logic last, input logic pinned,
                             input phd_pkg::res_item_t pin_val);
        int                gap;
        pin_t              pin;
        phd_pkg::rx_item_t it;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            gap = int'($urandom_range(1, 15));
        if (gap != 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pin.pinned = pinned;
        pin.val = pin_val;
        pinned_q = {pinned_q, pin};
        it.rx_byte = b;
        it.buffer_last = last;
        rx_valid <= 1'b1;
        rx_data <= it;
        do
            @(posedge clk);
        while (!rx_ready);
        item_count++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        rx_valid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [phd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic dir_row_t mid_row(input logic [7:0] b);
        dir_row_t r;
        r = '0;
        r.b = b;
        return r;
    endfunction

    function automatic dir_row_t end_row(input logic [7:0] b, input logic pv,
                                         input phd_pkg::err_t err,
                                         input logic [7:0] mt, input logic [15:0] pl);
        dir_row_t r;
        r.b = b;
        r.last = 1'b1;
        r.pinned = 1'b1;
        r.want.payload_valid = pv;
        r.want.payload_byte = pv ? b : 8'h00;
        r.want.frame_done = 1'b1;
        r.want.error_code = err;
        r.want.message_type = mt;
        r.want.payload_length = pl;
        return r;
    endfunction

    // half well-formed frames, plus excess, truncated, bad magic, short and noise
    task automatic send_frame();
        logic [7:0]  fr[$];
        logic [15:0] declared;
        int          pick;
        int          body;
        int          k;
        pick = int'($urandom_range(99));
        declared = ($urandom_range(19) == 0) ? 16'($urandom_range(255))
                                               : 16'($urandom_range(16));
        body = int'(declared);
        if (pick >= 50 && pick < 60)
            body = int'(declared) + int'($urandom_range(1, 6));
        else if (pick >= 60 && pick < 70)
        begin
            // header promises more than the buffer holds
            declared = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(17, 40));
            body = int'($urandom_range(0, 16));
        end
        fr = '{magic0_cfg, magic1_cfg, 8'($urandom), declared[7:0], declared[15:8]};
        if (pick >= 70 && pick < 80)
        begin
            k = int'($urandom_range(1));
            fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
        end
        repeat (body) fr = {fr, 8'($urandom)};
        if (pick >= 80 && pick < 88)
        begin
            k = int'($urandom_range(0, 3));
            fr = fr[0:k];
        end
        else if (pick >= 88)
        begin
            fr.delete();
            repeat ($urandom_range(1, 12)) fr = {fr, 8'($urandom)};
        end
        foreach (fr[i])
            push_byte(fr[i], i == fr.size() - 1, 1'b0, '0);
    endtask

    initial
    begin : stimulus
        int            phase_start;
        int            choice;
        logic [7:0]    m0;
        logic [7:0]    m1;
        rst_n = 1'b0;
        rx_valid = 1'b0;
        rx_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // magic is still the reset value of zero here
        dir_rows = '{
            end_row(8'h00, 1'b0, phd_pkg::ERR_SHORT, 8'h00, 16'h0000),
            mid_row(8'h00),
            mid_row(8'h00),
            end_row(8'h07, 1'b0, phd_pkg::ERR_SHORT, 8'h07, 16'h0000),
            mid_row(8'h00),
            mid_row(8'hFF),
            mid_row(8'h01),
            mid_row(8'h00),
            end_row(8'h00, 1'b0, phd_pkg::ERR_MAGIC, 8'h01, 16'h0000),
            mid_row(8'h00),
            mid_row(8'h00),
            mid_row(8'hFF),
            mid_row(8'h00),
            end_row(8'h00, 1'b0, phd_pkg::ERR_OK, 8'hFF, 16'h0000),
            mid_row(8'h00),
            mid_row(8'h00),
            mid_row(8'h80),
            mid_row(8'h01),
            mid_row(8'h00),
            end_row(8'hFF, 1'b1, phd_pkg::ERR_OK, 8'h80, 16'h0001),
            mid_row(8'h00),
            mid_row(8'h00),
            mid_row(8'h03),
            mid_row(8'h01),
            mid_row(8'h00),
            mid_row(8'h55),
            end_row(8'hAA, 1'b0, phd_pkg::ERR_SIZE, 8'h03, 16'h0001)
        };
        foreach (dir_rows[i])
            push_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].pinned, dir_rows[i].want);
        wait_drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin m0 = 8'hFF; m1 = 8'hFF; end
                1: begin m0 = 8'h00; m1 = 8'hFF; end
                2: begin m0 = 8'hFF; m1 = 8'h00; end
                default: begin m0 = 8'($urandom); m1 = 8'($urandom); end
            endcase
            write_reg(phd_pkg::REG_MAGIC_FIRST, m0);
            write_reg(phd_pkg::REG_MAGIC_SECOND, m1);
            // index past the register list must leave both magic bytes alone
            write_reg(phd_pkg::CFG_INDEX_W'($urandom_range(2, 255)), 8'($urandom));
            phase_start = item_count;
            while (item_count - phase_start < 300)
            begin
                choice = int'($urandom_range(3));
                idle_pct = (choice == 0) ? 0 : (choice == 1) ? 10 : (choice == 2) ? 30 : 60;
                send_frame();
            end
            wait_drain();
        end

        idle_pct = 0;
        repeat (20) send_frame();
        wait_drain();
        repeat (4) @(posedge clk);
        if (!mismatch_seen)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
